@@ src/akvcd_pkg.sv @@
// Package for the ASCII key/value command decoder.
// Holds the parse phase type, status and command codes, constants and the stage structs.
// No dependencies.
package akvcd_pkg;

    localparam int LINE_CAP_DEF = 32;

    typedef enum logic [2:0] {
        PH_KEY    = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_FAIL   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN   = 2'd2;
    localparam logic [1:0] ST_BAD_BUZZ  = 2'd3;

    localparam logic [3:0] CMD_NONE = 4'd0;
    localparam logic [3:0] CMD_V    = 4'd1;
    localparam logic [3:0] CMD_X    = 4'd2;
    localparam logic [3:0] CMD_Y    = 4'd3;
    localparam logic [3:0] CMD_H    = 4'd4;
    localparam logic [3:0] CMD_R    = 4'd5;
    localparam logic [3:0] CMD_L    = 4'd6;
    localparam logic [3:0] CMD_J    = 4'd7;
    localparam logic [3:0] CMD_E    = 4'd8;
    localparam logic [3:0] CMD_B    = 4'd9;
    localparam logic [3:0] CMD_C    = 4'd10;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPC   = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
    localparam logic [15:0] BUZZ_CMP    = 16'd500;
    localparam int          HEIGHT_MIN  = 60;
    localparam int          HEIGHT_MAX  = 210;
    localparam int          LINE_ERR_LIM = 1000;

    // Parsed line as seen at the line terminator.
    typedef struct packed {
        logic        line_end;   // terminator on a non-empty line
        logic        ok;         // key and at least one digit seen
        logic [7:0]  key;
        logic        neg;
        logic [31:0] mag;        // saturated magnitude, at most 2^31
    } t_line_info;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  command;
        logic [31:0] applied;
        logic [15:0] compare;
        logic        pwm_on;
    } t_result;

endpackage

@@ src/akvcd_parser.sv @@
// Line parser: character count, key capture, sign and saturating decimal accumulator.
// Depends on akvcd_pkg.
module akvcd_parser #(
    parameter int LINE_CAP = akvcd_pkg::LINE_CAP_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [7:0]             i_byte,
    output akvcd_pkg::t_line_info  o_info
);
    localparam int CW = $clog2(LINE_CAP);

    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_key, n_key;
    akvcd_pkg::t_phase r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [31:0]       r_acc, n_acc;

    logic        is_eol, is_digit, is_blank, is_sign;
    logic [35:0] acc_next;

    always_comb begin
        is_eol   = (i_byte == akvcd_pkg::CH_LF) || (i_byte == akvcd_pkg::CH_CR);
        is_digit = (i_byte >= akvcd_pkg::CH_ZERO) && (i_byte <= akvcd_pkg::CH_NINE);
        is_blank = (i_byte == akvcd_pkg::CH_SPC) || (i_byte == akvcd_pkg::CH_TAB) ||
                   (i_byte == akvcd_pkg::CH_VT) || (i_byte == akvcd_pkg::CH_FF);
        is_sign  = (i_byte == akvcd_pkg::CH_PLUS) || (i_byte == akvcd_pkg::CH_MINUS);
        // acc*10 + digit as shifts and adds
        acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                   {32'b0, i_byte[3:0]};
    end

    // next state
    always_comb begin
        n_count = r_count;
        n_key   = r_key;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_adv) begin
            if (is_eol) begin
                n_count = '0;
                n_key   = '0;
                n_phase = akvcd_pkg::PH_KEY;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else if (r_count < CW'(LINE_CAP - 1)) begin
                n_count = r_count + 1'b1;
                if (i_byte == akvcd_pkg::CH_NUL) begin
                    n_phase = ((r_phase == akvcd_pkg::PH_DIGITS) ||
                               (r_phase == akvcd_pkg::PH_DONE)) ?
                              akvcd_pkg::PH_DONE : akvcd_pkg::PH_FAIL;
                end else begin
                    case (r_phase)
                        akvcd_pkg::PH_KEY: begin
                            n_key   = i_byte;
                            n_phase = akvcd_pkg::PH_SPACE;
                        end
                        akvcd_pkg::PH_SPACE, akvcd_pkg::PH_SIGN,
                        akvcd_pkg::PH_DIGITS: begin
                            if (r_phase == akvcd_pkg::PH_SPACE && is_blank) begin
                                n_phase = r_phase;
                            end else if (r_phase == akvcd_pkg::PH_SPACE && is_sign) begin
                                n_neg   = (i_byte == akvcd_pkg::CH_MINUS);
                                n_phase = akvcd_pkg::PH_SIGN;
                            end else if (is_digit) begin
                                n_acc   = (acc_next > {4'b0, akvcd_pkg::MAG_LIMIT}) ?
                                          akvcd_pkg::MAG_LIMIT : acc_next[31:0];
                                n_phase = akvcd_pkg::PH_DIGITS;
                            end else begin
                                n_phase = (r_phase == akvcd_pkg::PH_DIGITS) ?
                                          akvcd_pkg::PH_DONE : akvcd_pkg::PH_FAIL;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_info.line_end = is_eol && (r_count != '0);
        o_info.ok       = (r_phase == akvcd_pkg::PH_DIGITS) ||
                          (r_phase == akvcd_pkg::PH_DONE);
        o_info.key      = r_key;
        o_info.neg      = r_neg;
        o_info.mag      = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_key   <= '0;
            r_phase <= akvcd_pkg::PH_KEY;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_count <= n_count;
            r_key   <= n_key;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

endmodule

@@ src/akvcd_exec.sv @@
// Command executor: converts the parsed line to a value, applies clamps, holds buzzer
// compare, run flag and the reload register, and forms the status result.
// Depends on akvcd_pkg.
module akvcd_exec (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_commit,     // line end taken this cycle
    input  akvcd_pkg::t_line_info i_info,
    output akvcd_pkg::t_result    o_result
);
    logic [15:0] r_reload;
    logic [15:0] r_compare, n_compare;
    logic        r_running, n_running;

    logic signed [31:0] val, applied;
    logic [1:0]         status;
    logic [3:0]         command;

    always_comb begin
        if (i_info.mag[31]) begin
            val = i_info.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            val = i_info.neg ? -$signed(i_info.mag) : $signed(i_info.mag);
        end
    end

    always_comb begin
        status    = akvcd_pkg::ST_OK;
        command   = akvcd_pkg::CMD_NONE;
        applied   = '0;
        n_compare = r_compare;
        n_running = r_running;
        if (!i_info.ok) begin
            status = akvcd_pkg::ST_MALFORMED;
        end else begin
            case (i_info.key)
                "V": begin command = akvcd_pkg::CMD_V; applied = val; end
                "X": begin command = akvcd_pkg::CMD_X; applied = val; end
                "Y": begin command = akvcd_pkg::CMD_Y; applied = val; end
                "R": begin command = akvcd_pkg::CMD_R; applied = val; end
                "H": begin
                    command = akvcd_pkg::CMD_H;
                    if (val < 32'(akvcd_pkg::HEIGHT_MIN)) begin
                        applied = 32'(akvcd_pkg::HEIGHT_MIN);
                    end else if (val > 32'(akvcd_pkg::HEIGHT_MAX)) begin
                        applied = 32'(akvcd_pkg::HEIGHT_MAX);
                    end else begin
                        applied = val;
                    end
                end
                "L": begin
                    command = akvcd_pkg::CMD_L;
                    if (val < -32'sd1000) begin
                        applied = -32'(akvcd_pkg::LINE_ERR_LIM);
                    end else if (val > 32'(akvcd_pkg::LINE_ERR_LIM)) begin
                        applied = 32'(akvcd_pkg::LINE_ERR_LIM);
                    end else begin
                        applied = val;
                    end
                end
                "J": begin command = akvcd_pkg::CMD_J; applied = {31'b0, val != 0}; end
                "E": begin command = akvcd_pkg::CMD_E; applied = {31'b0, val != 0}; end
                "B": begin
                    command = akvcd_pkg::CMD_B;
                    applied = val;
                    if (val == 0) begin
                        n_running = 1'b0;
                    end else if (val == 1 || val == 2) begin
                        n_compare = akvcd_pkg::BUZZ_CMP;
                        n_running = 1'b1;
                    end else begin
                        status = akvcd_pkg::ST_BAD_BUZZ;
                    end
                end
                "C": begin
                    command = akvcd_pkg::CMD_C;
                    if (val < 0) begin
                        applied = '0;
                    end else if (val > $signed({16'b0, r_reload})) begin
                        applied = {16'b0, r_reload};
                    end else begin
                        applied = val;
                    end
                    n_compare = applied[15:0];
                    n_running = 1'b1;
                end
                default: begin
                    status = akvcd_pkg::ST_UNKNOWN;
                end
            endcase
        end
        o_result.status  = status;
        o_result.command = command;
        o_result.applied = applied;
        o_result.compare = n_compare;
        o_result.pwm_on  = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload  <= 16'hFFFF;
            r_compare <= '0;
            r_running <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_reload <= i_cfg_data;
            end
            if (i_commit) begin
                r_compare <= n_compare;
                r_running <= n_running;
            end
        end
    end

endmodule

@@ src/ascii_key_value_command_decoder.sv @@
// ASCII key/value command decoder, top level; depends on akvcd_pkg, akvcd_parser, akvcd_exec.
// The byte is registered on accept and decoded straight into the output register, which
// then holds the line's status; a stalled output register can delay it.
// Throughput: one byte per cycle; only a stalled output register holds the input.
// Reset (synchronous, active low) clears the line parser and buzzer state and sets the
// reload register to 65535.
module ascii_key_value_command_decoder #(
    parameter int LINE_CAP = akvcd_pkg::LINE_CAP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_pwm_reload,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_command,
    output logic signed [31:0] o_applied_value,
    output logic [15:0] o_pwm_compare,
    output logic        o_pwm_on
);
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    akvcd_pkg::t_result r_out;

    logic                  out_free, adv, in_take, commit;
    akvcd_pkg::t_line_info info;
    akvcd_pkg::t_result    result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign commit     = adv && info.line_end;
    assign o_cfg_ready = 1'b1;

    akvcd_parser #(
        .LINE_CAP (LINE_CAP)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_info  (info)
    );

    akvcd_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_pwm_reload),
        .i_commit   (commit),
        .i_info     (info),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= commit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (commit) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_command       = r_out.command;
    assign o_applied_value = $signed(r_out.applied);
    assign o_pwm_compare   = r_out.compare;
    assign o_pwm_on        = r_out.pwm_on;

endmodule

@@ sim/ascii_key_value_command_checker.sv @@
// Scoreboard for ascii_key_value_command_decoder: follows byte and reload transactions,
// predicts the status transaction of every completed line and compares it field by field.
// Depends on akvcd_pkg.
module ascii_key_value_command_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_pwm_reload,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_applied_value,
    input  logic [15:0]        i_pwm_compare,
    input  logic               i_pwm_on,
    output int                 o_pending,
    output int                 o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import akvcd_pkg::*;

    localparam logic [7:0] KEY_V = "V";
    localparam logic [7:0] KEY_X = "X";
    localparam logic [7:0] KEY_Y = "Y";
    localparam logic [7:0] KEY_H = "H";
    localparam logic [7:0] KEY_R = "R";
    localparam logic [7:0] KEY_L = "L";
    localparam logic [7:0] KEY_J = "J";
    localparam logic [7:0] KEY_E = "E";
    localparam logic [7:0] KEY_B = "B";
    localparam logic [7:0] KEY_C = "C";
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    // predicted decoder state
    logic [15:0] reload;
    int          line_len;
    logic [7:0]  key;
    t_phase      phase;
    logic        neg;
    logic [31:0] mag;
    logic [15:0] compare;
    logic        buzz_on;
    int          mismatch_cnt;

    t_result line_status_q[$];

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic logic signed [31:0] clamp_s32(input logic signed [31:0] v,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic restart_line();
        line_len = 0;
        key      = '0;
        phase    = PH_KEY;
        neg      = 1'b0;
        mag      = '0;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic        digit;
        logic        try_digit;
        logic [63:0] acc;
        digit     = (c >= CH_ZERO) && (c <= CH_NINE);
        try_digit = 1'b0;
        if (c == CH_NUL) begin
            // NUL ends the text but keeps a complete number
            phase = (phase == PH_DIGITS || phase == PH_DONE) ? PH_DONE : PH_FAIL;
        end else begin
            case (phase)
                PH_KEY: begin
                    key   = c;
                    phase = PH_SPACE;
                end
                PH_SPACE: begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg   = (c == CH_MINUS);
                        phase = PH_SIGN;
                    end else if (!(c == CH_SPC || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
                        try_digit = 1'b1;
                    end
                end
                PH_SIGN, PH_DIGITS: try_digit = 1'b1;
                default: ;
            endcase
        end
        if (try_digit) begin
            if (digit) begin
                acc   = {32'd0, mag} * 64'd10 + 64'(c - CH_ZERO);
                mag   = (acc > 64'(MAG_LIMIT)) ? MAG_LIMIT : acc[31:0];
                phase = PH_DIGITS;
            end else begin
                phase = (phase == PH_DIGITS) ? PH_DONE : PH_FAIL;
            end
        end
    endtask

    task automatic close_line(output t_result r);
        logic signed [31:0] val;
        r.status  = ST_OK;
        r.command = CMD_NONE;
        r.applied = '0;
        if (phase != PH_DIGITS && phase != PH_DONE) begin
            r.status = ST_MALFORMED;
        end else begin
            if (mag >= MAG_LIMIT)
                val = neg ? S32_MIN : S32_MAX;
            else
                val = neg ? -$signed(mag) : $signed(mag);
            case (key)
                KEY_V: begin r.command = CMD_V; r.applied = val; end
                KEY_X: begin r.command = CMD_X; r.applied = val; end
                KEY_Y: begin r.command = CMD_Y; r.applied = val; end
                KEY_R: begin r.command = CMD_R; r.applied = val; end
                KEY_H: begin
                    r.command = CMD_H;
                    r.applied = clamp_s32(val, HEIGHT_MIN, HEIGHT_MAX);
                end
                KEY_L: begin
                    r.command = CMD_L;
                    r.applied = clamp_s32(val, -LINE_ERR_LIM, LINE_ERR_LIM);
                end
                KEY_J: begin r.command = CMD_J; r.applied = {31'd0, val != 0}; end
                KEY_E: begin r.command = CMD_E; r.applied = {31'd0, val != 0}; end
                KEY_B: begin
                    r.command = CMD_B;
                    r.applied = val;
                    if (val == 0) begin
                        buzz_on = 1'b0;
                    end else if (val == 1 || val == 2) begin
                        compare = BUZZ_CMP;
                        buzz_on = 1'b1;
                    end else begin
                        r.status = ST_BAD_BUZZ;
                    end
                end
                KEY_C: begin
                    r.command = CMD_C;
                    r.applied = clamp_s32(val, 0, $signed({16'd0, reload}));
                    compare   = r.applied[15:0];
                    buzz_on   = 1'b1;
                end
                default: r.status = ST_UNKNOWN;
            endcase
        end
        r.compare = compare;
        r.pwm_on  = buzz_on;
    endtask

    task automatic decode_rx_byte(input logic [7:0] c);
        t_result r;
        if (c == CH_LF || c == CH_CR) begin
            if (line_len > 0) begin
                close_line(r);
                line_status_q.push_back(r);
            end
            restart_line();
        end else if (line_len < LINE_CAP_DEF - 1) begin
            line_len++;
            parse_char(c);
        end
    endtask

    task automatic check_line_status();
        t_result want;
        if (line_status_q.size() == 0) begin
            report_mismatch("status transaction with no line pending", i_status, ST_OK);
        end else begin
            want = line_status_q.pop_front();
            if (i_status !== want.status)
                report_mismatch("status", i_status, want.status);
            if (i_command !== want.command)
                report_mismatch("command", i_command, want.command);
            if (i_applied_value !== want.applied)
                report_mismatch("applied_value", i_applied_value, want.applied);
            if (i_pwm_compare !== want.compare)
                report_mismatch("pwm_compare", i_pwm_compare, want.compare);
            if (i_pwm_on !== want.pwm_on)
                report_mismatch("pwm_on", i_pwm_on, want.pwm_on);
        end
    endtask

    initial mismatch_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reload  = 16'hFFFF;
            compare = '0;
            buzz_on = 1'b0;
            restart_line();
            line_status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                reload = i_cfg_pwm_reload;
            if (i_out_valid && !i_out_stall)
                check_line_status();
            if (i_in_valid && !i_in_stall)
                decode_rx_byte(i_rx_byte);
        end
        o_pending    <= line_status_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

@@ sim/ascii_key_value_command_decoder_tb.sv @@
// Testbench top for ascii_key_value_command_decoder: drives directed and random command
// lines and reload writes, and gives the verdict. Depends on akvcd_pkg, the decoder RTL
// and ascii_key_value_command_checker.
module ascii_key_value_command_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import akvcd_pkg::*;

    localparam int RANDOM_BYTES   = 1470;
    localparam int RANDOM_PHASES  = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic [7:0]  i_rx_byte        = '0;
    logic        i_cfg_valid      = 1'b0;
    logic [15:0] i_cfg_pwm_reload = '0;
    logic        i_out_stall      = 1'b0;
    logic        o_in_stall;
    logic        o_cfg_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_command;
    logic signed [31:0] o_applied_value;
    logic [15:0] o_pwm_compare;
    logic        o_pwm_on;

    int pending_lines;
    int mismatches;
    int snd_idle_pct = 29;
    int rcv_idle_pct = 62;
    int sent_bytes   = 0;
    int quiet_cycles = 0;

    ascii_key_value_command_decoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_pwm_reload (i_cfg_pwm_reload),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_applied_value  (o_applied_value),
        .o_pwm_compare    (o_pwm_compare),
        .o_pwm_on         (o_pwm_on)
    );

    ascii_key_value_command_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_pwm_reload (i_cfg_pwm_reload),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_command        (o_command),
        .i_applied_value  (o_applied_value),
        .i_pwm_compare    (o_pwm_compare),
        .i_pwm_on         (o_pwm_on),
        .o_pending        (pending_lines),
        .o_mismatches     (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CH_CR);
    endtask

    // hold the sender until every line status is back, plus the pipeline depth
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lines != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reload(input logic [15:0] v);
        drain();
        i_cfg_valid      <= 1'b1;
        i_cfg_pwm_reload <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_line();
        logic [7:0] line_q[$];
        string      keys;
        int         roll;
        int         ndig;
        keys = "VXYHRLJEBC";
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
            // key, blanks, sign, digits, maybe a trailer
            if ($urandom_range(0, 19) == 0)
                line_q.push_back(8'($urandom_range(33, 126)));
            else
                line_q.push_back(keys[$urandom_range(0, 9)]);
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 3))
                    0: line_q.push_back(CH_SPC);
                    1: line_q.push_back(CH_TAB);
                    2: line_q.push_back(CH_VT);
                    default: line_q.push_back(CH_FF);
                endcase
            end
            case ($urandom_range(0, 3))
                0: line_q.push_back(CH_PLUS);
                1: line_q.push_back(CH_MINUS);
                default: ;
            endcase
            roll = $urandom_range(0, 9);
            ndig = (roll < 5) ? 1 : (roll < 8) ? $urandom_range(2, 5) :
                   (roll < 9) ? $urandom_range(6, 10) : $urandom_range(11, 14);
            repeat (ndig) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            case ($urandom_range(0, 9))
                0: line_q.push_back(8'($urandom_range(14, 255)));
                1: begin
                    line_q.push_back(CH_NUL);
                    line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                default: ;
            endcase
        end else if (roll < 93) begin
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            // overlong: the tail past the cap must be dropped
            line_q.push_back(keys[$urandom_range(0, 9)]);
            repeat ($urandom_range(30, 44)) begin
                if ($urandom_range(0, 7) == 0)
                    line_q.push_back(CH_SPC);
                else
                    line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        case ($urandom_range(0, 3))
            0: line_q.push_back(CH_CR);
            1: line_q.push_back(CH_LF);
            2: begin line_q.push_back(CH_CR); line_q.push_back(CH_LF); end
            default: begin line_q.push_back(CH_LF); line_q.push_back(CH_LF); end
        endcase
        foreach (line_q[i]) send_byte(line_q[i]);
    endtask

    initial begin
        logic [15:0] reload_plan[RANDOM_PHASES];
        int          target;
        reload_plan = '{16'd1000, 16'hFFFF, 16'd0, 16'($urandom), 16'd1, 16'($urandom)};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines, reload still at its reset value
        send_line("V123");
        send_text("X-45");
        send_byte(CH_LF);
        send_text("Y");
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_byte(CH_TAB);
        send_line(" +7");
        send_line("H5");
        send_line("H999");
        send_line("R-2147483648");
        send_line("L-5000");
        send_line("J0");
        send_line("E17");
        send_line("B2");
        send_line("B0");
        send_line("B7");
        send_line("B-1");
        send_line("B1");
        send_line("C70000");
        send_line("Z12");
        send_line("V");
        send_byte(CH_LF);
        send_line("V99999999999");
        send_line("V-99999999999");
        send_text("V12");
        send_byte(CH_NUL);
        send_line(" 34");
        send_byte(CH_NUL);
        send_line("V1");
        send_line("V+-3");
        send_line("V5x");
        send_text("X");
        repeat (29) send_byte(CH_SPC);
        send_line("78");
        write_reload(16'd0);
        send_line("C5");
        send_line("C-1");

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reload(reload_plan[p]);
            if (p < 2) begin
                snd_idle_pct = 29;
                rcv_idle_pct = 62;
            end else if (p < 4) begin
                snd_idle_pct = 62;
                rcv_idle_pct = 29;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            target = sent_bytes + RANDOM_BYTES / RANDOM_PHASES;
            while (sent_bytes < target) send_random_line();
        end

        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
